### rtl/core/tcpq_pkg.sv
// shared constants, opcodes and types for the two-class priority queue
// no dependencies
package tcpq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned ID_BITS_DEF  = 16;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned OP_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 2'd0,
    OP_SERVE_PRF = 2'd1,
    OP_SERVE_OLD = 2'd2,
    OP_WITHDRAW  = 2'd3
  } op_t;

endpackage

### rtl/core/tcpq_if.sv
// valid/ready channel interfaces for the queue's input and result beats
// depends on tcpq_pkg
interface tcpq_in_if;
  logic                       valid;
  logic                       ready;
  logic [tcpq_pkg::OP_W-1:0]  opcode;
  logic [tcpq_pkg::ID_W-1:0]  person_id;
  logic                       is_preferred;
  modport source (output valid, opcode, person_id, is_preferred, input ready);
  modport sink   (input valid, opcode, person_id, is_preferred, output ready);
endinterface

interface tcpq_out_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [tcpq_pkg::ID_W-1:0]  served_id;
  modport source (output valid, ok, served_id, input ready);
  modport sink   (input valid, ok, served_id, output ready);
endinterface

### rtl/core/tcpq_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies
module tcpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/two_class_priority_queue.sv
// Two-class priority queue with cancel. Ids and preferred flags sit in one
// RAM in arrival order, slot 0 the oldest; up to CAPACITY unique ids are held.
// Each input beat gives exactly one result beat. One operation at a time:
// a scan reads the slots one per cycle (search for duplicates, the preferred
// entry or a withdrawn id), then a compaction pass moves later slots up one
// per cycle, re-using the single RAM read port. Ids wider than ID_BITS are
// truncated; the result register frees the input side once taken.
// depends on tcpq_pkg, tcpq_if, tcpq_ram
module two_class_priority_queue #(
  parameter int unsigned CAPACITY = tcpq_pkg::CAPACITY_DEF,
  parameter int unsigned ID_BITS  = tcpq_pkg::ID_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tcpq_in_if.sink    in_ch,
  tcpq_out_if.source out_ch
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = ID_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR, S_RESP
  } state_t;

  state_t                   state_r;
  logic [CW-1:0]            occ_r;
  logic [CW-1:0]            idx_r;      // slot being presented by the ram
  logic [CW-1:0]            hit_r;      // found position
  logic                     found_r;
  tcpq_pkg::op_t            op_r;
  logic [ID_BITS-1:0]       id_r;
  logic                     pref_r;
  logic                     ok_r;
  logic [tcpq_pkg::ID_W-1:0] served_r;

  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic [DW-1:0]            wdata, rdata;
  logic [CW-1:0]            rd_idx;
  logic                     match;

  tcpq_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // scan target for the slot now at rdata
  always_comb begin
    case (op_r)
      tcpq_pkg::OP_SERVE_PRF: match = rdata[ID_BITS];
      tcpq_pkg::OP_SERVE_OLD: match = 1'b1;
      default:                match = (rdata[ID_BITS-1:0] == id_r);
    endcase
  end

  // ram port control
  always_comb begin
    rd_idx = '0;
    we     = 1'b0;
    waddr  = '0;
    wdata  = rdata;
    if (state_r == S_IDLE) begin
      rd_idx = '0;
    end else if (state_r == S_SCAN) begin
      rd_idx = idx_r + 1'b1;
    end else if (state_r == S_DECIDE || state_r == S_SHIFT_RD ||
                 state_r == S_SHIFT_WR) begin
      rd_idx = idx_r + 1'b1;
    end
    if (state_r == S_DECIDE && op_r == tcpq_pkg::OP_INSERT && !found_r &&
        occ_r < CW'(CAPACITY)) begin
      we    = 1'b1;
      waddr = occ_r[AW-1:0];
      wdata = {pref_r, id_r};
    end else if (state_r == S_SHIFT_WR) begin
      we    = 1'b1;
      waddr = idx_r[AW-1:0] - 1'b1;
    end
    raddr = (rd_idx < CW'(CAPACITY)) ? rd_idx[AW-1:0] : '0;
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = (state_r == S_RESP);
  assign out_ch.ok        = ok_r;
  assign out_ch.served_id = served_r;

  // sequencer: scan, decide, compact, respond
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      idx_r   <= '0;
      hit_r   <= '0;
      found_r <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r     <= tcpq_pkg::op_t'(in_ch.opcode);
            id_r     <= ID_BITS'(in_ch.person_id);
            pref_r   <= in_ch.is_preferred;
            idx_r    <= '0;
            found_r  <= 1'b0;
            hit_r    <= '0;
            served_r <= '0;
            ok_r     <= 1'b0;
            state_r  <= (occ_r == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          // slot idx_r is on rdata now; the oldest id is kept in case
          // no preferred entry turns up
          if (!found_r && match) begin
            found_r <= 1'b1;
            hit_r   <= idx_r;
          end
          if (!found_r && (match || idx_r == '0)) begin
            served_r <= tcpq_pkg::ID_W'(rdata[ID_BITS-1:0]);
          end
          if (idx_r + 1'b1 >= occ_r || (!found_r && match)) begin
            state_r <= S_DECIDE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DECIDE: begin
          case (op_r)
            tcpq_pkg::OP_INSERT: begin
              if (!found_r && occ_r < CW'(CAPACITY)) begin
                occ_r <= occ_r + 1'b1;
                ok_r  <= 1'b1;
              end
              served_r <= '0;
              state_r  <= S_RESP;
            end
            tcpq_pkg::OP_SERVE_PRF, tcpq_pkg::OP_SERVE_OLD: begin
              if (occ_r == '0) begin
                served_r <= '0;
                state_r  <= S_RESP;
              end else begin
                ok_r <= 1'b1;
                // no preferred entry: the oldest goes
                if (!found_r) begin
                  hit_r <= '0;
                end
                idx_r   <= (found_r ? hit_r : '0);
                state_r <= S_SHIFT_RD;
              end
            end
            default: begin
              served_r <= '0;
              if (found_r) begin
                ok_r    <= 1'b1;
                idx_r   <= hit_r;
                state_r <= S_SHIFT_RD;
              end else begin
                state_r <= S_RESP;
              end
            end
          endcase
        end
        S_SHIFT_RD: begin
          // read of idx_r+1 issued here, shows on rdata next cycle
          if (idx_r + 1'b1 >= occ_r) begin
            occ_r   <= occ_r - 1'b1;
            state_r <= S_RESP;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          // rdata holds slot idx_r, written to idx_r-1
          if (idx_r + 1'b1 >= occ_r) begin
            occ_r   <= occ_r - 1'b1;
            state_r <= S_RESP;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_RESP: begin
          if (out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY)) else $error("occupancy above capacity");
  a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && !ok_r) |-> served_r == '0)
    else $error("failed operation shows an id");
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> (occ_r == $past(occ_r)))
    else $error("occupancy moved while idle");
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_DECIDE || state_r == S_SHIFT_WR))
    else $error("ram written outside an operation");
`endif
endmodule
